// ===== rtl/core/trilat_pkg.sv =====
// ----------------------------------------------------------------------------
// trilat_pkg: shared constants and helpers for the trilateration pipeline
// Range field width, quotient width and the 32-bit saturating quotient fix-up.
// ----------------------------------------------------------------------------
package trilat_pkg;

  localparam int RANGE_W    = 16;
  localparam int QUOT_W     = 32;
  localparam int OUT_DATA_W = 2 * QUOT_W;

  localparam logic [QUOT_W-1:0] POS_MAX = {1'b0, {(QUOT_W-1){1'b1}}};
  localparam logic [QUOT_W-1:0] POS_MIN = {1'b1, {(QUOT_W-1){1'b0}}};

  // q is the quotient magnitude, over marks a magnitude of 2^32 or more
  function automatic logic [QUOT_W-1:0] sat_quot(input logic [QUOT_W-1:0] q,
                                                 input logic              neg,
                                                 input logic              over);
    logic [QUOT_W-1:0] res;
    if (neg) begin
      res = (over || (q > POS_MIN)) ? POS_MIN : (~q + QUOT_W'(1));
    end else begin
      res = (over || (q > POS_MAX)) ? POS_MAX : q;
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/trilateration_position_top.sv =====
// ----------------------------------------------------------------------------
// trilateration_position_top: 2D position from three anchors and ranges
// Linear trilateration solved by Cramer's rule, fully pipelined.
// ----------------------------------------------------------------------------
// One query per clock unless the skid slot is full; from input transfer to
// out_tvalid: seven arithmetic stages (differences, products, sums, split
// partial products, recombination, numerator subtraction, magnitudes), one
// overflow-check stage, a 32-stage restoring divider that settles one quotient
// bit per stage for both coordinates against a shared determinant, and the
// output register. A second result slot behind the output register lets the
// pipeline keep moving while a result waits; in_tready falls only when both
// slots are full. A zero determinant gives degenerate = 1 with zero positions;
// quotients truncate toward zero and saturate to signed 32 bits.
// ----------------------------------------------------------------------------
module trilateration_position_top #(
  parameter  int COORD_WIDTH = 16,
  localparam int IN_W = ((6 * COORD_WIDTH + 3 * trilat_pkg::RANGE_W + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // anchor1_x, anchor1_y, anchor1_range, anchor2_x, anchor2_y, anchor2_range,
  // anchor3_x, anchor3_y, anchor3_range
  input  logic [IN_W-1:0]                   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // pos_x, pos_y
  output logic [trilat_pkg::OUT_DATA_W-1:0] out_tdata,
  // degenerate
  output logic                              out_tuser
);

  localparam int CW   = COORD_WIDTH;
  localparam int RW   = trilat_pkg::RANGE_W;
  localparam int QW   = trilat_pkg::QUOT_W;
  localparam int NDIV = trilat_pkg::QUOT_W;
  localparam int DW   = CW + 1;
  localparam int PDW  = 2 * DW;
  localparam int DETW = PDW + 2;
  localparam int CWW  = ((PDW > 2 * RW + 1) ? PDW : 2 * RW + 1) + 2;
  localparam int SPL  = CWW / 2;
  localparam int LOPW = SPL + 1 + DW;
  localparam int HIPW = CWW - SPL + DW;
  localparam int PW   = CWW + DW;
  localparam int NUMW = PW + 1;
  localparam int REMW = DETW + 1;
  localparam int ODW  = trilat_pkg::OUT_DATA_W;

  logic adv;

  // input fields
  logic signed [CW-1:0] x1, y1, x2, y2, x3, y3;
  logic [RW-1:0]        r1, r2, r3;

  assign x1 = $signed(in_tdata[CW-1:0]);
  assign y1 = $signed(in_tdata[2*CW-1:CW]);
  assign r1 = in_tdata[2*CW+RW-1:2*CW];
  assign x2 = $signed(in_tdata[3*CW+RW-1:2*CW+RW]);
  assign y2 = $signed(in_tdata[4*CW+RW-1:3*CW+RW]);
  assign r2 = in_tdata[4*CW+2*RW-1:4*CW+RW];
  assign x3 = $signed(in_tdata[5*CW+2*RW-1:4*CW+2*RW]);
  assign y3 = $signed(in_tdata[6*CW+2*RW-1:5*CW+2*RW]);
  assign r3 = in_tdata[6*CW+3*RW-1:6*CW+2*RW];

  // stage 1: differences and sums
  logic                 s1_v_r;
  logic signed [DW-1:0] s1_dx1_r, s1_sx1_r, s1_dy1_r, s1_sy1_r;
  logic signed [DW-1:0] s1_dx2_r, s1_sx2_r, s1_dy2_r, s1_sy2_r;
  logic [RW-1:0]        s1_r1_r, s1_r2_r, s1_r3_r;

  // stage 2: products
  logic                  s2_v_r;
  logic signed [PDW-1:0] s2_pd1_r, s2_pd2_r;
  logic signed [PDW-1:0] s2_qx1_r, s2_qy1_r, s2_qx2_r, s2_qy2_r;
  logic [2*RW-1:0]       s2_rr1_r, s2_rr2_r, s2_rr3_r;
  logic signed [DW-1:0]  s2_dx1_r, s2_dy1_r, s2_dx2_r, s2_dy2_r;

  // stage 3: determinant and right-hand sides
  logic                   s3_v_r;
  logic signed [DETW-1:0] s3_det_r;
  logic signed [CWW-1:0]  s3_c1_r, s3_c2_r;
  logic signed [DW-1:0]   s3_dx1_r, s3_dy1_r, s3_dx2_r, s3_dy2_r;

  // stage 4: split partial products
  logic                   s4_v_r;
  logic signed [DETW-1:0] s4_det_r;
  logic signed [HIPW-1:0] s4_axh_r, s4_bxh_r, s4_ayh_r, s4_byh_r;
  logic signed [LOPW-1:0] s4_axl_r, s4_bxl_r, s4_ayl_r, s4_byl_r;

  // stage 5: recombined products
  logic                   s5_v_r;
  logic signed [DETW-1:0] s5_det_r;
  logic signed [PW-1:0]   s5_pax_r, s5_pbx_r, s5_pay_r, s5_pby_r;

  // stage 6: numerators
  logic                   s6_v_r;
  logic signed [DETW-1:0] s6_det_r;
  logic signed [NUMW-1:0] s6_numx_r, s6_numy_r;

  // stage 7: magnitudes and signs
  logic              s7_v_r;
  logic [DETW-1:0]   s7_dmag_r;
  logic [NUMW-1:0]   s7_nmx_r, s7_nmy_r;
  logic              s7_negx_r, s7_negy_r, s7_deg_r;

  // divider stages, index 0 is the overflow check
  logic            dv_v_r    [0:NDIV];
  logic [REMW-1:0] dv_remx_r [0:NDIV];
  logic [REMW-1:0] dv_remy_r [0:NDIV];
  logic [QW-1:0]   dv_qx_r   [0:NDIV];
  logic [QW-1:0]   dv_qy_r   [0:NDIV];
  logic [DETW-1:0] dv_d_r    [0:NDIV];
  logic            dv_negx_r [0:NDIV];
  logic            dv_negy_r [0:NDIV];
  logic            dv_ovx_r  [0:NDIV];
  logic            dv_ovy_r  [0:NDIV];
  logic            dv_deg_r  [0:NDIV];

  logic [REMW-1:0] dv_remx_nxt [0:NDIV];
  logic [REMW-1:0] dv_remy_nxt [0:NDIV];
  logic [QW-1:0]   dv_qx_nxt   [0:NDIV];
  logic [QW-1:0]   dv_qy_nxt   [0:NDIV];
  logic            dv_ovx_nxt, dv_ovy_nxt;

  // output register and skid slot
  logic           out_v_r, sk_v_r;
  logic           out_v_nxt, sk_v_nxt;
  logic           load_out, load_sk, push;
  logic [ODW-1:0] out_data_r, sk_data_r, res_data;
  logic           out_deg_r, sk_deg_r;

  assign adv       = ~sk_v_r;
  assign in_tready = adv;

  // stage 1..7 data path
  logic signed [SPL:0]       c1lo, c2lo;
  logic signed [CWW-SPL-1:0] c1hi, c2hi;

  assign c1lo = $signed({1'b0, s3_c1_r[SPL-1:0]});
  assign c2lo = $signed({1'b0, s3_c2_r[SPL-1:0]});
  assign c1hi = $signed(s3_c1_r[CWW-1:SPL]);
  assign c2hi = $signed(s3_c2_r[CWW-1:SPL]);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx1_r <= DW'(x2) - DW'(x1);
      s1_sx1_r <= DW'(x2) + DW'(x1);
      s1_dy1_r <= DW'(y2) - DW'(y1);
      s1_sy1_r <= DW'(y2) + DW'(y1);
      s1_dx2_r <= DW'(x3) - DW'(x2);
      s1_sx2_r <= DW'(x3) + DW'(x2);
      s1_dy2_r <= DW'(y3) - DW'(y2);
      s1_sy2_r <= DW'(y3) + DW'(y2);
      s1_r1_r  <= r1;
      s1_r2_r  <= r2;
      s1_r3_r  <= r3;

      s2_pd1_r <= PDW'(s1_dx1_r) * PDW'(s1_dy2_r);
      s2_pd2_r <= PDW'(s1_dx2_r) * PDW'(s1_dy1_r);
      s2_qx1_r <= PDW'(s1_dx1_r) * PDW'(s1_sx1_r);
      s2_qy1_r <= PDW'(s1_dy1_r) * PDW'(s1_sy1_r);
      s2_qx2_r <= PDW'(s1_dx2_r) * PDW'(s1_sx2_r);
      s2_qy2_r <= PDW'(s1_dy2_r) * PDW'(s1_sy2_r);
      s2_rr1_r <= (2*RW)'(s1_r1_r) * (2*RW)'(s1_r1_r);
      s2_rr2_r <= (2*RW)'(s1_r2_r) * (2*RW)'(s1_r2_r);
      s2_rr3_r <= (2*RW)'(s1_r3_r) * (2*RW)'(s1_r3_r);
      s2_dx1_r <= s1_dx1_r;
      s2_dy1_r <= s1_dy1_r;
      s2_dx2_r <= s1_dx2_r;
      s2_dy2_r <= s1_dy2_r;

      // det and numerators both carry half the textbook factor
      s3_det_r <= (DETW'(s2_pd1_r) - DETW'(s2_pd2_r)) <<< 1;
      s3_c1_r  <= CWW'($signed({1'b0, s2_rr1_r})) - CWW'($signed({1'b0, s2_rr2_r}))
                  + CWW'(s2_qx1_r) + CWW'(s2_qy1_r);
      s3_c2_r  <= CWW'($signed({1'b0, s2_rr2_r})) - CWW'($signed({1'b0, s2_rr3_r}))
                  + CWW'(s2_qx2_r) + CWW'(s2_qy2_r);
      s3_dx1_r <= s2_dx1_r;
      s3_dy1_r <= s2_dy1_r;
      s3_dx2_r <= s2_dx2_r;
      s3_dy2_r <= s2_dy2_r;

      s4_det_r <= s3_det_r;
      s4_axh_r <= HIPW'(c1hi) * HIPW'(s3_dy2_r);
      s4_axl_r <= LOPW'(c1lo) * LOPW'(s3_dy2_r);
      s4_bxh_r <= HIPW'(c2hi) * HIPW'(s3_dy1_r);
      s4_bxl_r <= LOPW'(c2lo) * LOPW'(s3_dy1_r);
      s4_ayh_r <= HIPW'(c2hi) * HIPW'(s3_dx1_r);
      s4_ayl_r <= LOPW'(c2lo) * LOPW'(s3_dx1_r);
      s4_byh_r <= HIPW'(c1hi) * HIPW'(s3_dx2_r);
      s4_byl_r <= LOPW'(c1lo) * LOPW'(s3_dx2_r);

      s5_det_r <= s4_det_r;
      s5_pax_r <= (PW'(s4_axh_r) <<< SPL) + PW'(s4_axl_r);
      s5_pbx_r <= (PW'(s4_bxh_r) <<< SPL) + PW'(s4_bxl_r);
      s5_pay_r <= (PW'(s4_ayh_r) <<< SPL) + PW'(s4_ayl_r);
      s5_pby_r <= (PW'(s4_byh_r) <<< SPL) + PW'(s4_byl_r);

      s6_det_r  <= s5_det_r;
      s6_numx_r <= NUMW'(s5_pax_r) - NUMW'(s5_pbx_r);
      s6_numy_r <= NUMW'(s5_pay_r) - NUMW'(s5_pby_r);

      s7_dmag_r <= s6_det_r[DETW-1] ? DETW'(-s6_det_r) : DETW'(s6_det_r);
      s7_nmx_r  <= s6_numx_r[NUMW-1] ? NUMW'(-s6_numx_r) : NUMW'(s6_numx_r);
      s7_nmy_r  <= s6_numy_r[NUMW-1] ? NUMW'(-s6_numy_r) : NUMW'(s6_numy_r);
      s7_negx_r <= s6_numx_r[NUMW-1] ^ s6_det_r[DETW-1];
      s7_negy_r <= s6_numy_r[NUMW-1] ^ s6_det_r[DETW-1];
      s7_deg_r  <= (s6_det_r == '0);
    end
  end

  // divider: stage 0 checks for a quotient of 2^32 or more, then one bit a stage
  logic [REMW-1:0] hx_ext, hy_ext;
  logic [REMW-1:0] trx [1:NDIV];
  logic [REMW-1:0] try_ [1:NDIV];
  logic            gex [1:NDIV];
  logic            gey [1:NDIV];

  assign hx_ext = REMW'(s7_nmx_r[NUMW-1:QW]);
  assign hy_ext = REMW'(s7_nmy_r[NUMW-1:QW]);

  always_comb begin
    dv_ovx_nxt     = (hx_ext >= REMW'(s7_dmag_r));
    dv_ovy_nxt     = (hy_ext >= REMW'(s7_dmag_r));
    dv_remx_nxt[0] = hx_ext;
    dv_remy_nxt[0] = hy_ext;
    dv_qx_nxt[0]   = s7_nmx_r[QW-1:0];
    dv_qy_nxt[0]   = s7_nmy_r[QW-1:0];
    for (int k = 1; k <= NDIV; k++) begin
      trx[k]  = {dv_remx_r[k-1][REMW-2:0], dv_qx_r[k-1][QW-1]};
      try_[k] = {dv_remy_r[k-1][REMW-2:0], dv_qy_r[k-1][QW-1]};
      gex[k]  = (trx[k] >= REMW'(dv_d_r[k-1]));
      gey[k]  = (try_[k] >= REMW'(dv_d_r[k-1]));
      dv_remx_nxt[k] = gex[k] ? (trx[k] - REMW'(dv_d_r[k-1])) : trx[k];
      dv_remy_nxt[k] = gey[k] ? (try_[k] - REMW'(dv_d_r[k-1])) : try_[k];
      dv_qx_nxt[k]   = {dv_qx_r[k-1][QW-2:0], gex[k]};
      dv_qy_nxt[k]   = {dv_qy_r[k-1][QW-2:0], gey[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_remx_r[0] <= dv_remx_nxt[0];
      dv_remy_r[0] <= dv_remy_nxt[0];
      dv_qx_r[0]   <= dv_qx_nxt[0];
      dv_qy_r[0]   <= dv_qy_nxt[0];
      dv_d_r[0]    <= s7_dmag_r;
      dv_negx_r[0] <= s7_negx_r;
      dv_negy_r[0] <= s7_negy_r;
      dv_ovx_r[0]  <= dv_ovx_nxt;
      dv_ovy_r[0]  <= dv_ovy_nxt;
      dv_deg_r[0]  <= s7_deg_r;
      for (int k = 1; k <= NDIV; k++) begin
        dv_remx_r[k] <= dv_remx_nxt[k];
        dv_remy_r[k] <= dv_remy_nxt[k];
        dv_qx_r[k]   <= dv_qx_nxt[k];
        dv_qy_r[k]   <= dv_qy_nxt[k];
        dv_d_r[k]    <= dv_d_r[k-1];
        dv_negx_r[k] <= dv_negx_r[k-1];
        dv_negy_r[k] <= dv_negy_r[k-1];
        dv_ovx_r[k]  <= dv_ovx_r[k-1];
        dv_ovy_r[k]  <= dv_ovy_r[k-1];
        dv_deg_r[k]  <= dv_deg_r[k-1];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      for (int k = 0; k <= NDIV; k++) begin
        dv_v_r[k] <= 1'b0;
      end
    end else if (adv) begin
      s1_v_r    <= in_tvalid;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      s4_v_r    <= s3_v_r;
      s5_v_r    <= s4_v_r;
      s6_v_r    <= s5_v_r;
      s7_v_r    <= s6_v_r;
      dv_v_r[0] <= s7_v_r;
      for (int k = 1; k <= NDIV; k++) begin
        dv_v_r[k] <= dv_v_r[k-1];
      end
    end
  end

  // saturation and output slots
  assign res_data = dv_deg_r[NDIV] ? '0 :
                    {trilat_pkg::sat_quot(dv_qy_r[NDIV], dv_negy_r[NDIV], dv_ovy_r[NDIV]),
                     trilat_pkg::sat_quot(dv_qx_r[NDIV], dv_negx_r[NDIV], dv_ovx_r[NDIV])};

  assign push = dv_v_r[NDIV] & adv;

  always_comb begin
    out_v_nxt = out_v_r;
    sk_v_nxt  = sk_v_r;
    load_out  = 1'b0;
    load_sk   = 1'b0;
    if (!out_v_r || out_tready) begin
      out_v_nxt = sk_v_r | push;
      sk_v_nxt  = 1'b0;
      load_out  = 1'b1;
    end else if (push) begin
      sk_v_nxt = 1'b1;
      load_sk  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      sk_v_r  <= sk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= sk_v_r ? sk_data_r : res_data;
      out_deg_r  <= sk_v_r ? sk_deg_r : dv_deg_r[NDIV];
    end
    if (load_sk) begin
      sk_data_r <= res_data;
      sk_deg_r  <= dv_deg_r[NDIV];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_deg_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |-> out_v_r)
    else $error("skid slot full while output register empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sk_v_r) |-> $past(out_v_r && !out_tready && dv_v_r[NDIV]))
    else $error("skid slot filled without a stalled output");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("degenerate result with nonzero position");

  a_deg_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_v_r[0] && dv_deg_r[0]) |-> (dv_d_r[0] == '0))
    else $error("degenerate flag with nonzero divisor");

endmodule

// ===== tb/trilateration_position_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trilateration_position_top_tb: self-checking bench for the 2D trilateration
// A short table of directed queries (degenerate layouts, exact solutions,
// saturation, extreme coordinates) then randomly built queries, sent in bursts
// against a stalling receiver, checked by table or integer Cramer solver.
// ----------------------------------------------------------------------------
module trilateration_position_top_tb;

  localparam int RANGE_W      = trilat_pkg::RANGE_W;
  localparam int QUOT_W       = trilat_pkg::QUOT_W;
  localparam int OUT_DATA_W   = trilat_pkg::OUT_DATA_W;
  localparam int COORD_W      = 16;
  localparam int IN_W         = ((6 * COORD_W + 3 * RANGE_W + 7) / 8) * 8;
  localparam int N_RANDOM     = 550;
  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_LIMIT  = 1000;

  // anchor1_x in the lowest bits
  typedef struct packed {
    logic [RANGE_W-1:0] anchor3_range;
    logic [COORD_W-1:0] anchor3_y;
    logic [COORD_W-1:0] anchor3_x;
    logic [RANGE_W-1:0] anchor2_range;
    logic [COORD_W-1:0] anchor2_y;
    logic [COORD_W-1:0] anchor2_x;
    logic [RANGE_W-1:0] anchor1_range;
    logic [COORD_W-1:0] anchor1_y;
    logic [COORD_W-1:0] anchor1_x;
  } anchor_query_t;

  typedef struct packed {
    logic              degenerate;
    logic [QUOT_W-1:0] pos_y;
    logic [QUOT_W-1:0] pos_x;
  } position_t;

  typedef struct {
    anchor_query_t query;
    bit            known;
    position_t     result;
  } query_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  query_row_t query_table[$];
  position_t  pending_positions[$];
  int         errors = 0;
  int         idle_cycles = 0;
  logic [9:0] rx_cycle = '0;

  trilateration_position_top #(.COORD_WIDTH(COORD_W)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  function automatic anchor_query_t mk_query(int x1, int y1, int r1, int x2, int y2, int r2,
                                             int x3, int y3, int r3);
    anchor_query_t q;
    q.anchor1_x = COORD_W'(x1); q.anchor1_y = COORD_W'(y1); q.anchor1_range = RANGE_W'(r1);
    q.anchor2_x = COORD_W'(x2); q.anchor2_y = COORD_W'(y2); q.anchor2_range = RANGE_W'(r2);
    q.anchor3_x = COORD_W'(x3); q.anchor3_y = COORD_W'(y3); q.anchor3_range = RANGE_W'(r3);
    return q;
  endfunction

  function automatic position_t mk_pos(logic [QUOT_W-1:0] px, logic [QUOT_W-1:0] py,
                                       logic deg);
    position_t p;
    p.pos_x = px; p.pos_y = py; p.degenerate = deg;
    return p;
  endfunction

  function automatic logic [QUOT_W-1:0] clamp_quot(logic signed [127:0] q);
    logic [QUOT_W-1:0] r;
    if (q > $signed(trilat_pkg::POS_MAX)) r = trilat_pkg::POS_MAX;
    else if (q < $signed(trilat_pkg::POS_MIN)) r = trilat_pkg::POS_MIN;
    else r = q[QUOT_W-1:0];
    return r;
  endfunction

  // Cramer's rule on the two difference equations, exact wide integers
  function automatic position_t solve_position(anchor_query_t q);
    logic signed [127:0] x1, y1, r1, x2, y2, r2, x3, y3, r3;
    logic signed [127:0] a1, b1, a2, b2, c1, c2, det;
    position_t p;
    x1 = $signed(q.anchor1_x); y1 = $signed(q.anchor1_y); r1 = q.anchor1_range;
    x2 = $signed(q.anchor2_x); y2 = $signed(q.anchor2_y); r2 = q.anchor2_range;
    x3 = $signed(q.anchor3_x); y3 = $signed(q.anchor3_y); r3 = q.anchor3_range;
    a1 = 2 * (x2 - x1);
    b1 = 2 * (y2 - y1);
    a2 = 2 * (x3 - x2);
    b2 = 2 * (y3 - y2);
    c1 = r1 * r1 - r2 * r2 + x2 * x2 - x1 * x1 + y2 * y2 - y1 * y1;
    c2 = r2 * r2 - r3 * r3 + x3 * x3 - x2 * x2 + y3 * y3 - y2 * y2;
    det = a1 * b2 - a2 * b1;
    if (det == 0) begin
      p = mk_pos('0, '0, 1'b1);
    end else begin
      p = mk_pos(clamp_quot((c1 * b2 - c2 * b1) / det),
                 clamp_quot((c2 * a1 - c1 * a2) / det), 1'b0);
    end
    return p;
  endfunction

  function automatic anchor_query_t random_query();
    int mode, x1, y1, dx, dy, k, s;
    anchor_query_t q;
    mode = $urandom_range(99);
    x1 = int'($urandom_range(2000)) - 1000;
    y1 = int'($urandom_range(2000)) - 1000;
    if (mode < 40) begin
      q = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    end else if (mode < 70) begin
      q = mk_query(x1, y1, $urandom_range(2000),
                   int'($urandom_range(2000)) - 1000, int'($urandom_range(2000)) - 1000,
                   $urandom_range(2000),
                   int'($urandom_range(2000)) - 1000, int'($urandom_range(2000)) - 1000,
                   $urandom_range(2000));
    end else if (mode < 85) begin
      // collinear or coincident anchors
      dx = int'($urandom_range(200)) - 100;
      dy = int'($urandom_range(200)) - 100;
      k  = int'($urandom_range(4)) - 2;
      q = mk_query(x1, y1, $urandom, x1 + dx, y1 + dy, $urandom,
                   x1 + dx + k * dx, y1 + dy + k * dy, $urandom);
    end else begin
      // tiny determinant, large numerators
      k = $urandom_range(30000);
      s = $urandom_range(1) ? 1 : -1;
      q = mk_query(x1, y1, $urandom, x1 + s, y1 + s, $urandom,
                   x1 + s * (k + 1), y1 + s * (k + 2), $urandom);
    end
    return q;
  endfunction

  task automatic add_row(anchor_query_t q, bit known, position_t r);
    query_row_t row;
    row.query = q; row.known = known; row.result = r;
    query_table.push_back(row);
  endtask

  // receiver: stall pattern picked by rx_cycle[9:8] from four modes in turn
  always @(posedge clk) begin
    position_t exp_pos;
    rx_cycle <= rx_cycle + 1'b1;
    case (rx_cycle[9:8])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= 1'($urandom_range(1));
      2'd2: out_tready <= (rx_cycle[1:0] == 2'd0);
      default: out_tready <= ($urandom_range(9) != 0);
    endcase
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_positions.size() == 0) begin
        $error("result transfer with no query outstanding");
        errors++;
      end else begin
        exp_pos = pending_positions.pop_front();
        if (out_tdata[QUOT_W-1:0] !== exp_pos.pos_x) begin
          $error("pos_x: expected %0d, got %0d", $signed(exp_pos.pos_x),
                 $signed(out_tdata[QUOT_W-1:0]));
          errors++;
        end
        if (out_tdata[2*QUOT_W-1:QUOT_W] !== exp_pos.pos_y) begin
          $error("pos_y: expected %0d, got %0d", $signed(exp_pos.pos_y),
                 $signed(out_tdata[2*QUOT_W-1:QUOT_W]));
          errors++;
        end
        if (out_tuser !== exp_pos.degenerate) begin
          $error("degenerate: expected %0b, got %0b", exp_pos.degenerate, out_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $error("no transfer for %0d cycles", STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int         total, next_idx, accepted, burst_left, gap_left;
    query_row_t cur_row;

    add_row(mk_query(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_pos('0, '0, 1'b1));
    add_row(mk_query(-32768, -32768, 65535, -32768, -32768, 65535, -32768, -32768, 65535),
            1'b1, mk_pos('0, '0, 1'b1));
    add_row(mk_query(0, 0, 10, 100, 0, 200, -200, 0, 300), 1'b1, mk_pos('0, '0, 1'b1));
    add_row(mk_query(10, 20, 7, 300, -400, 9, 300, -400, 11), 1'b1, mk_pos('0, '0, 1'b1));
    add_row(mk_query(-5, 7, 1, -5, 7, 2, 90, 40, 3), 1'b1, mk_pos('0, '0, 1'b1));
    add_row(mk_query(0, 0, 5, 6, 0, 5, 0, 8, 5), 1'b1, mk_pos(32'sd3, 32'sd4, 1'b0));
    add_row(mk_query(0, 0, 5, -6, 0, 5, 0, -8, 5), 1'b1, mk_pos(-32'sd3, -32'sd4, 1'b0));
    add_row(mk_query(0, 0, 7, 6, 0, 5, 0, 8, 5), 1'b0, '0);
    add_row(mk_query(0, 0, 7, -6, 0, 5, 0, -8, 5), 1'b0, '0);
    // near-singular layout: both coordinates saturate
    add_row(mk_query(0, 0, 65535, 1, 1, 0, 30001, 30002, 0), 1'b1,
            mk_pos(trilat_pkg::POS_MAX, trilat_pkg::POS_MIN, 1'b0));
    add_row(mk_query(0, 0, 0, 1, 1, 65535, 30001, 30002, 0), 1'b1,
            mk_pos(trilat_pkg::POS_MIN, trilat_pkg::POS_MAX, 1'b0));
    add_row(mk_query(-32768, -32768, 65535, 32767, -32768, 65535, -32768, 32767, 65535),
            1'b0, '0);
    add_row(mk_query(32767, 32767, 0, -32768, 32767, 0, 32767, -32768, 0), 1'b0, '0);
    add_row(mk_query(-1, 0, 16'hAAAA, 21845, -21846, 16'h5555, -21846, 21845, 65535),
            1'b0, '0);
    add_row(mk_query(32767, -32768, 1, -32768, -32767, 65534, 1, 32767, 32768), 1'b0, '0);

    total      = query_table.size() + N_RANDOM;
    next_idx   = 0;
    accepted   = 0;
    burst_left = $urandom_range(1, 24);
    gap_left   = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted < total) begin
      @(posedge clk);
      if (in_tvalid && in_tready) begin
        pending_positions.push_back(cur_row.known ? cur_row.result
                                                  : solve_position(cur_row.query));
        accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (next_idx < total) begin
          if (next_idx < query_table.size()) begin
            cur_row = query_table[next_idx];
          end else begin
            cur_row.query = random_query();
            cur_row.known = 1'b0;
          end
          in_tdata  <= cur_row.query;
          in_tvalid <= 1'b1;
          next_idx++;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end

    while (pending_positions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
